/* hdl/mobile_ip_registration_client_assert.svh */
`ifndef MOBILE_IP_REGISTRATION_CLIENT_ASSERT_SVH
`define MOBILE_IP_REGISTRATION_CLIENT_ASSERT_SVH
// implication checked every cycle outside reset
`define MIPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mipc check failed");
// implication checked in the following cycle
`define MIPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mipc check failed");
`endif

/* hdl/mipc_pkg.sv */
package mipc_pkg;
  localparam int ADV_ENTRIES = 8;
  localparam int PENDING_ENTRIES = 8;
  localparam logic [15:0] RESET_SEQ_LIMIT = 16'd256;
  localparam logic [15:0] RENEW_MARGIN = 16'd10;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADVERT = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic REG_NODE_ADDR = 1'b0;
  localparam logic REG_AGENT_ADDR = 1'b1;

  localparam logic [2:0] STATUS_NONE = 3'd0;
  localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
  localparam logic [2:0] STATUS_DENIED = 3'd2;
  localparam logic [2:0] STATUS_UNMATCHED = 3'd3;
  localparam logic [2:0] STATUS_FULL = 3'd4;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] data;
    logic [15:0] life;
    logic [15:0] rem;
  } entry_t;

  typedef enum logic [1:0] {OP_HOLD, OP_DEC, OP_REMOVE, OP_APPEND} op_t;

  typedef struct packed {
    op_t op;
    logic by_zero;
    logic [31:0] key;
    entry_t wr;
  } tcmd_t;

  typedef struct packed {
    logic hit;
    entry_t ent;
  } link_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PDEC, ST_PZAP, ST_ADEC, ST_AZAP, ST_TFIND, ST_TFIN,
    ST_AFIND, ST_AINS, ST_RFIND, ST_RFIN, ST_OUT
  } state_t;
endpackage

/* hdl/mobile_ip_registration_client.sv */
// Sequencing: a tick decrements and sweeps out expired pending entries, then
//   advertisements, then looks up the current agent; an advertisement and a reply
//   each do a lookup and a finishing step. One request at a time; in_ready rises with
//   out_valid, the tick's expiry sweep making it the longest request.
// Reset (rst, synchronous): both tables empty, unregistered, addresses and
//   counters zero; configuration registers cleared.
module mobile_ip_registration_client (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [31:0] write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] adv_coa,
  input  logic [15:0] adv_lifetime,
  input  logic [15:0] adv_reg_lifetime,
  input  logic [15:0] adv_sequence,
  input  logic [31:0] reply_ident_low,
  input  logic [7:0]  reply_code,
  input  logic [15:0] reply_lifetime,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        request_valid,
  output logic [31:0] request_care_of,
  output logic [15:0] request_lifetime,
  output logic [31:0] ident_high,
  output logic [31:0] ident_low,
  output logic [31:0] gateway,
  output logic        registered,
  output logic [2:0]  status
);
  localparam int NA = mipc_pkg::ADV_ENTRIES;
  localparam int NP = mipc_pkg::PENDING_ENTRIES;

  mipc_pkg::state_t state, state_next;

  logic [31:0] own_addr, agent_addr;
  logic        is_registered, rereg_done;
  logic [31:0] current_agent, gateway_addr, ident_up, ident_down;
  logic [15:0] reg_remaining;

  logic [31:0] q_coa, q_rid;
  logic [15:0] q_alife, q_rlife, q_seq, q_replife;
  logic [7:0]  q_code;

  logic             look_hit;
  mipc_pkg::entry_t look_ent;

  logic        res_req;
  logic [31:0] res_coa, res_ih, res_il;
  logic [15:0] res_life;
  logic [2:0]  res_status;

  mipc_pkg::tcmd_t  a_cmd, p_cmd;
  mipc_pkg::link_t  a_link [NA+1];
  mipc_pkg::link_t  p_link [NP+1];
  mipc_pkg::entry_t a_ent [NA];
  mipc_pkg::entry_t p_ent [NP];
  logic [NA-1:0]    a_used;
  logic [NP-1:0]    p_used;

  assign a_link[0] = '0;
  assign p_link[0] = '0;

  for (genvar i = 0; i < NA; i++) begin : g_adv
    mipc_cell u_cell (
      .clk(clk), .rst(rst), .cmd(a_cmd), .link_in(a_link[i]),
      .prev_used((i == 0) ? 1'b1 : a_used[(i == 0) ? 0 : i-1]),
      .nb_ent((i == NA-1) ? '0 : a_ent[(i == NA-1) ? i : i+1]),
      .nb_used((i == NA-1) ? 1'b0 : a_used[(i == NA-1) ? i : i+1]),
      .link_out(a_link[i+1]), .ent(a_ent[i]), .used(a_used[i])
    );
  end

  for (genvar i = 0; i < NP; i++) begin : g_pend
    mipc_cell u_cell (
      .clk(clk), .rst(rst), .cmd(p_cmd), .link_in(p_link[i]),
      .prev_used((i == 0) ? 1'b1 : p_used[(i == 0) ? 0 : i-1]),
      .nb_ent((i == NP-1) ? '0 : p_ent[(i == NP-1) ? i : i+1]),
      .nb_used((i == NP-1) ? 1'b0 : p_used[(i == NP-1) ? i : i+1]),
      .link_out(p_link[i+1]), .ent(p_ent[i]), .used(p_used[i])
    );
  end

  logic        a_found, p_found, a_full, p_full;
  assign a_found = a_link[NA].hit;
  assign p_found = p_link[NP].hit;
  assign a_full = a_used[NA-1];
  assign p_full = p_used[NP-1];

  assign in_ready = (state == mipc_pkg::ST_IDLE);

  // decisions of the finishing steps
  logic        send;
  logic [31:0] send_coa;
  logic [15:0] send_life;
  logic        reg_upd;
  logic        reg_val;
  logic        rereg_set;
  logic        agent_clr;
  logic        gw_upd;
  logic [31:0] gw_val;
  logic        status_upd;
  logic [2:0]  status_val;
  logic        adv_ins;
  logic [15:0] rr_dec, prev_seq;
  logic        lost, reg_mid;
  logic signed [17:0] v;

  always_comb begin
    send = 1'b0;
    send_coa = '0;
    send_life = '0;
    reg_upd = 1'b0;
    reg_val = is_registered;
    rereg_set = 1'b0;
    agent_clr = 1'b0;
    gw_upd = 1'b0;
    gw_val = '0;
    status_upd = 1'b0;
    status_val = mipc_pkg::STATUS_NONE;
    adv_ins = 1'b0;
    rr_dec = reg_remaining - 16'd1;
    prev_seq = look_hit ? look_ent.data[15:0] : 16'd0;
    lost = is_registered && !look_hit;
    reg_mid = is_registered;
    v = $signed({2'b00, look_ent.rem}) - $signed({2'b00, look_ent.life})
        + $signed({2'b00, q_replife});
    case (state)
      mipc_pkg::ST_TFIN: begin
        if (lost) begin
          reg_upd = 1'b1;
          reg_val = 1'b0;
          reg_mid = 1'b0;
          if (a_used[0]) begin
            send = 1'b1;
            send_coa = a_ent[0].key;
            send_life = (a_ent[0].key != agent_addr) ? a_ent[0].data[31:16] : 16'd0;
            gw_upd = 1'b1;
            gw_val = a_ent[0].key;
          end
        end
        if (reg_remaining != 16'd0) begin
          if (rr_dec == 16'd0) begin
            reg_upd = 1'b1;
            reg_val = 1'b0;
            agent_clr = 1'b1;
          end else if (rr_dec <= mipc_pkg::RENEW_MARGIN && !rereg_done && reg_mid) begin
            rereg_set = 1'b1;
            if (look_hit) begin
              send = 1'b1;
              send_coa = look_ent.key;
              send_life = look_ent.data[31:16];
            end
          end
        end
      end
      mipc_pkg::ST_AINS: begin
        if (q_seq < mipc_pkg::RESET_SEQ_LIMIT && prev_seq > q_seq) begin
          reg_upd = 1'b1;
          reg_val = 1'b0;
          reg_mid = 1'b0;
        end
        if (a_full) begin
          status_upd = 1'b1;
          status_val = mipc_pkg::STATUS_FULL;
        end else begin
          adv_ins = 1'b1;
        end
        if (!reg_mid) begin
          send = 1'b1;
          send_coa = q_coa;
          send_life = (q_coa != agent_addr) ? q_rlife : 16'd0;
          gw_upd = 1'b1;
          gw_val = q_coa;
        end
      end
      mipc_pkg::ST_RFIN: begin
        status_upd = 1'b1;
        if (!look_hit) begin
          status_val = mipc_pkg::STATUS_UNMATCHED;
        end else if (q_code > 8'd1) begin
          status_val = mipc_pkg::STATUS_DENIED;
        end else begin
          status_val = mipc_pkg::STATUS_ACCEPTED;
          reg_upd = 1'b1;
          reg_val = 1'b1;
          gw_upd = 1'b1;
          gw_val = look_ent.data;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mipc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (command)
            mipc_pkg::CMD_TICK: state_next = mipc_pkg::ST_PDEC;
            mipc_pkg::CMD_ADVERT: state_next = mipc_pkg::ST_AFIND;
            mipc_pkg::CMD_REPLY: state_next = mipc_pkg::ST_RFIND;
            default: state_next = mipc_pkg::ST_OUT;
          endcase
        end
      end
      mipc_pkg::ST_PDEC: state_next = mipc_pkg::ST_PZAP;
      mipc_pkg::ST_PZAP: if (!p_found) state_next = mipc_pkg::ST_ADEC;
      mipc_pkg::ST_ADEC: state_next = mipc_pkg::ST_AZAP;
      mipc_pkg::ST_AZAP: if (!a_found) state_next = mipc_pkg::ST_TFIND;
      mipc_pkg::ST_TFIND: state_next = mipc_pkg::ST_TFIN;
      mipc_pkg::ST_TFIN: state_next = mipc_pkg::ST_OUT;
      mipc_pkg::ST_AFIND: state_next = mipc_pkg::ST_AINS;
      mipc_pkg::ST_AINS: state_next = mipc_pkg::ST_OUT;
      mipc_pkg::ST_RFIND: state_next = mipc_pkg::ST_RFIN;
      mipc_pkg::ST_RFIN: state_next = mipc_pkg::ST_OUT;
      mipc_pkg::ST_OUT: if (!out_valid || out_ready) state_next = mipc_pkg::ST_IDLE;
      default: state_next = mipc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    a_cmd = '0;
    p_cmd = '0;
    a_cmd.op = mipc_pkg::OP_HOLD;
    p_cmd.op = mipc_pkg::OP_HOLD;
    a_cmd.wr = '{key: q_coa, data: {q_rlife, q_seq}, life: 16'd0, rem: q_alife};
    p_cmd.wr = '{key: ident_down, data: send_coa, life: send_life, rem: send_life};
    case (state)
      mipc_pkg::ST_PDEC: p_cmd.op = mipc_pkg::OP_DEC;
      mipc_pkg::ST_PZAP: begin
        p_cmd.op = mipc_pkg::OP_REMOVE;
        p_cmd.by_zero = 1'b1;
      end
      mipc_pkg::ST_ADEC: a_cmd.op = mipc_pkg::OP_DEC;
      mipc_pkg::ST_AZAP: begin
        a_cmd.op = mipc_pkg::OP_REMOVE;
        a_cmd.by_zero = 1'b1;
      end
      mipc_pkg::ST_TFIND: a_cmd.key = current_agent;
      mipc_pkg::ST_AFIND: begin
        a_cmd.op = mipc_pkg::OP_REMOVE;
        a_cmd.key = q_coa;
      end
      mipc_pkg::ST_RFIND: p_cmd.key = q_rid;
      mipc_pkg::ST_RFIN: begin
        p_cmd.key = q_rid;
        if (look_hit && q_code <= 8'd1) p_cmd.op = mipc_pkg::OP_REMOVE;
      end
      default: begin
      end
    endcase
    if (adv_ins) a_cmd.op = mipc_pkg::OP_APPEND;
    if (send && !p_full) p_cmd.op = mipc_pkg::OP_APPEND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mipc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
      agent_addr <= '0;
      is_registered <= 1'b0;
      rereg_done <= 1'b0;
      current_agent <= '0;
      reg_remaining <= '0;
      gateway_addr <= '0;
      ident_up <= '0;
      ident_down <= '0;
      out_valid <= 1'b0;
    end else begin
      if (write_enable) begin
        if (write_index == mipc_pkg::REG_NODE_ADDR) begin
          own_addr <= write_data;
          ident_up <= write_data;
          ident_down <= write_data;
        end else begin
          agent_addr <= write_data;
        end
      end
      if (reg_upd) is_registered <= reg_val;
      if (rereg_set) rereg_done <= 1'b1;
      if (gw_upd) gateway_addr <= gw_val;
      if (agent_clr) current_agent <= '0;
      if (state == mipc_pkg::ST_TFIN && reg_remaining != 16'd0) reg_remaining <= rr_dec;
      if (state == mipc_pkg::ST_RFIN && status_val == mipc_pkg::STATUS_ACCEPTED) begin
        current_agent <= look_ent.data;
        rereg_done <= 1'b0;
        reg_remaining <= v[17] ? 16'd0 : (v[16] ? 16'hFFFF : v[15:0]);
      end
      if (send) begin
        ident_up <= ident_up + 32'd1;
        ident_down <= ident_down - 32'd1;
      end
      if (state == mipc_pkg::ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_coa <= adv_coa;
      q_alife <= adv_lifetime;
      q_rlife <= adv_reg_lifetime;
      q_seq <= adv_sequence;
      q_rid <= reply_ident_low;
      q_code <= reply_code;
      q_replife <= reply_lifetime;
      res_req <= 1'b0;
      res_coa <= '0;
      res_life <= '0;
      res_ih <= '0;
      res_il <= '0;
      res_status <= mipc_pkg::STATUS_NONE;
    end
    if (state == mipc_pkg::ST_TFIND) begin
      look_hit <= a_found;
      look_ent <= a_link[NA].ent;
    end
    if (state == mipc_pkg::ST_AFIND) begin
      look_hit <= a_found;
      look_ent <= a_link[NA].ent;
    end
    if (state == mipc_pkg::ST_RFIND) begin
      look_hit <= p_found;
      look_ent <= p_link[NP].ent;
    end
    if (send && p_full) begin
      res_status <= mipc_pkg::STATUS_FULL;
    end else if (status_upd) begin
      res_status <= status_val;
    end
    if (send) begin
      res_req <= 1'b1;
      res_coa <= send_coa;
      res_life <= send_life;
      res_ih <= ident_up;
      res_il <= ident_down;
    end
    if (state == mipc_pkg::ST_OUT && (!out_valid || out_ready)) begin
      request_valid <= res_req;
      request_care_of <= res_coa;
      request_lifetime <= res_life;
      ident_high <= res_ih;
      ident_low <= res_il;
      gateway <= gateway_addr;
      registered <= is_registered;
      status <= res_status;
    end
  end
endmodule

/* hdl/mipc_cell.sv */
module mipc_cell (
  input  logic             clk,
  input  logic             rst,
  input  mipc_pkg::tcmd_t  cmd,
  input  mipc_pkg::link_t  link_in,
  input  logic             prev_used,
  input  mipc_pkg::entry_t nb_ent,
  input  logic             nb_used,
  output mipc_pkg::link_t  link_out,
  output mipc_pkg::entry_t ent,
  output logic             used
);
  logic match;

  assign match = used && (cmd.by_zero ? (ent.rem == 16'd0) : (ent.key == cmd.key));
  assign link_out = link_in.hit ? link_in : '{hit: match, ent: ent};

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      case (cmd.op)
        mipc_pkg::OP_REMOVE: begin
          if (link_in.hit || match) begin
            used <= nb_used;
          end
        end
        mipc_pkg::OP_APPEND: begin
          if (!used && prev_used) begin
            used <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mipc_pkg::OP_DEC: begin
        if (used) begin
          ent.rem <= ent.rem - 16'd1;
        end
      end
      mipc_pkg::OP_REMOVE: begin
        if (link_in.hit || match) begin
          ent <= nb_ent;
        end
      end
      mipc_pkg::OP_APPEND: begin
        if (!used && prev_used) begin
          ent <= cmd.wr;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

/* hdl/mipc_checker.sv */
`include "mobile_ip_registration_client_assert.svh"
module mipc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        request_valid,
  input logic [31:0] request_care_of,
  input logic [15:0] request_lifetime,
  input logic [31:0] ident_high,
  input logic [31:0] ident_low,
  input logic [2:0]  status
);
  logic req_zero;

  assign req_zero = (request_care_of == 32'd0) && (request_lifetime == 16'd0) &&
                    (ident_high == 32'd0) && (ident_low == 32'd0);

  `MIPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MIPC_ASSERT_IMP(a_status_range, out_valid, status <= 3'd4)
  `MIPC_ASSERT_IMP(a_no_req_zero, out_valid && !request_valid, req_zero)
  `MIPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule

bind mobile_ip_registration_client mipc_checker u_mipc_checker (.*);
